// ===== design/s8dp_pkg.sv =====
// ----------------------------------------------------------------------------
// s8dp_pkg: shared types and constants for the s8 dot-product block
// Element and digit widths, product and accumulator widths, the stage control
// type and the digit-composed lane product.
// ----------------------------------------------------------------------------
package s8dp_pkg;

  // Widths of the operand elements and their 4-bit digits.
  localparam int EL_W       = 8;
  localparam int DIGIT_BITS = 4;

  // Digit weights as shift amounts: 16 and 256.
  localparam int MID_SHIFT = 4;
  localparam int TOP_SHIFT = 8;

  // An s8 x s8 product fits 16 bits signed.
  localparam int PROD_W    = 16;
  localparam int ACC_W     = 64;
  localparam int SUM_OUT_W = 32;

  // Default number of lanes.
  localparam int LANES_DEF = 4;

  // Control that travels alongside the payload of one pipeline stage.
  typedef struct packed {
    logic valid;
    logic last;
  } ctrl_t;

  // Product of two s8 elements formed from four 4-bit digit products.
  function automatic logic signed [PROD_W-1:0] lane_product(
    input logic [EL_W-1:0] a,
    input logic [EL_W-1:0] b
  );
    logic        [DIGIT_BITS-1:0]   al;
    logic        [DIGIT_BITS-1:0]   bl;
    logic signed [DIGIT_BITS-1:0]   ah;
    logic signed [DIGIT_BITS-1:0]   bh;
    logic        [2*DIGIT_BITS-1:0] ll;
    logic signed [2*DIGIT_BITS:0]   lh;
    logic signed [2*DIGIT_BITS:0]   hl;
    logic signed [2*DIGIT_BITS-1:0] hh;
    logic signed [PROD_W-1:0]       mid;
    al  = a[DIGIT_BITS-1:0];
    bl  = b[DIGIT_BITS-1:0];
    ah  = $signed(a[EL_W-1:DIGIT_BITS]);
    bh  = $signed(b[EL_W-1:DIGIT_BITS]);
    ll  = al * bl;
    lh  = $signed({1'b0, al}) * bh;
    hl  = ah * $signed({1'b0, bl});
    hh  = ah * bh;
    mid = PROD_W'(lh) + PROD_W'(hl);
    return $signed(PROD_W'(ll)) + (mid <<< MID_SHIFT) + (PROD_W'(hh) <<< TOP_SHIFT);
  endfunction

endpackage

// ===== design/s8dp_if.sv =====
// ----------------------------------------------------------------------------
// s8dp_if: valid/ready channels of the s8 dot-product block
// The input channel carries the packed lane elements and the last flag; the
// output channel carries the wrapped sum and the overflow flag.
// ----------------------------------------------------------------------------
interface s8dp_in_if #(
  parameter int LANES = s8dp_pkg::LANES_DEF
);
  import s8dp_pkg::*;

  logic                    valid;
  logic                    ready;
  // Element i of each operand sits in bits [8*i+7 : 8*i].
  logic [LANES*EL_W-1:0]   a;
  logic [LANES*EL_W-1:0]   b;
  logic                    last;

  modport source (output valid, output a, output b, output last, input ready);
  modport sink   (input valid, input a, input b, input last, output ready);
endinterface

interface s8dp_out_if;
  import s8dp_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [SUM_OUT_W-1:0] sum;
  logic                        overflow;

  modport source (output valid, output sum, output overflow, input ready);
  modport sink   (input valid, input sum, input overflow, output ready);
endinterface

// ===== design/s8dp_lane.sv =====
// ----------------------------------------------------------------------------
// s8dp_lane: one multiply lane
// Splits both elements into digits, forms the weighted digit products and
// registers the lane product.
// ----------------------------------------------------------------------------
module s8dp_lane (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [s8dp_pkg::EL_W-1:0]            a,
  input  logic [s8dp_pkg::EL_W-1:0]            b,
  output logic signed [s8dp_pkg::PROD_W-1:0]   prod
);
  import s8dp_pkg::*;

  // Product register, loaded whenever the stage advances.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= lane_product(a, b);
    end
  end

endmodule

// ===== design/s8dp_merge.sv =====
// ----------------------------------------------------------------------------
// s8dp_merge: lane merging stage
// Adds the lane products in a balanced tree and registers the item sum
// together with its control.
// ----------------------------------------------------------------------------
module s8dp_merge #(
  parameter int LANES = s8dp_pkg::LANES_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic signed [s8dp_pkg::PROD_W-1:0]                prod [LANES],
  input  s8dp_pkg::ctrl_t                                   ctrl_in,
  input  logic                                              acc_ready,
  output logic                                              ready,
  output s8dp_pkg::ctrl_t                                   ctrl_out,
  output logic signed [s8dp_pkg::PROD_W+$clog2(LANES)-1:0]  isum
);
  import s8dp_pkg::*;

  localparam int LEVELS = $clog2(LANES);
  localparam int SPAN   = 1 << LEVELS;
  localparam int SW     = PROD_W + LEVELS;

  logic signed [SW-1:0] node [LEVELS+1][SPAN];
  logic                 drain;

  // Adder tree; missing leaves are zero.
  always_comb begin
    for (int l = 0; l <= LEVELS; l++) begin
      for (int i = 0; i < SPAN; i++) begin
        node[l][i] = '0;
      end
    end
    for (int i = 0; i < LANES; i++) begin
      node[0][i] = SW'(prod[i]);
    end
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < (SPAN >> (l + 1)); i++) begin
        node[l+1][i] = node[l][2*i] + node[l][2*i+1];
      end
    end
  end

  // A held item leaves unless it is a last item and the result slot is busy.
  assign drain = ctrl_out.valid && (!ctrl_out.last || acc_ready);
  assign ready = !ctrl_out.valid || drain;

  // Stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (ready) begin
      ctrl_out <= ctrl_in;
    end
  end

  // Item sum register.
  always_ff @(posedge clk) begin
    if (ready) begin
      isum <= node[LEVELS][0];
    end
  end

endmodule

// ===== design/s8dp_accum.sv =====
// ----------------------------------------------------------------------------
// s8dp_accum: accumulator and result register
// Adds each item sum into the 64-bit accumulator; on a last item it loads the
// wrapped sum and the range flag into the result register and clears.
// ----------------------------------------------------------------------------
module s8dp_accum #(
  parameter int LANES = s8dp_pkg::LANES_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  s8dp_pkg::ctrl_t                                   ctrl_in,
  input  logic signed [s8dp_pkg::PROD_W+$clog2(LANES)-1:0]  isum,
  output logic                                              acc_ready,
  s8dp_out_if.source                                        dout
);
  import s8dp_pkg::*;

  logic signed [ACC_W-1:0]         acc;
  logic signed [ACC_W-1:0]         acc_sum;
  logic [ACC_W-SUM_OUT_W:0]        top_bits;
  logic                            fire;
  logic                            out_of_range;

  // The result slot is free when empty or being emptied this cycle.
  assign acc_ready = !dout.valid || dout.ready;
  assign fire      = ctrl_in.valid && (!ctrl_in.last || acc_ready);

  // New total and its signed 32-bit range check.
  assign acc_sum      = acc + ACC_W'(isum);
  assign top_bits     = acc_sum[ACC_W-1:SUM_OUT_W-1];
  assign out_of_range = !((&top_bits) || !(|top_bits));

  // Accumulator and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      dout.valid <= 1'b0;
    end else begin
      if (fire) begin
        acc <= ctrl_in.last ? '0 : acc_sum;
      end
      if (fire && ctrl_in.last) begin
        dout.valid <= 1'b1;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire && ctrl_in.last) begin
      dout.sum      <= acc_sum[SUM_OUT_W-1:0];
      dout.overflow <= out_of_range;
    end
  end

  // The accumulator starts over after a last item.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && ctrl_in.last |=> acc == '0)
    else $error("accumulator not cleared after last item");

  // No result appears without a last item reaching this stage.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !dout.valid && !(fire && ctrl_in.last) |=> !dout.valid)
    else $error("result raised without a last item");

  // Reset leaves an empty result slot and a zero total.
  a_reset_state: assert property (@(posedge clk)
    rst |=> acc == '0 && !dout.valid)
    else $error("reset did not clear accumulator state");

endmodule

// ===== design/s8_dot_product_nibble_composed.sv =====
// ----------------------------------------------------------------------------
// s8_dot_product_nibble_composed: signed 8-bit dot-product accumulator
// Lanes form s8 x s8 products from 4-bit digit products, a tree merges them
// and a 64-bit accumulator sums items until the last one of a vector.
// Path: a last item accepted at the input passes through the lane register,
// the merge register and the result register before its result is valid.
// Throughput: one item per cycle; a last item waits only while the result
// register still holds an untaken result.
// Reset: clears all stage valids, the accumulator and the result valid.
// ----------------------------------------------------------------------------
module s8_dot_product_nibble_composed #(
  parameter int LANES = s8dp_pkg::LANES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  s8dp_in_if.sink    din,
  s8dp_out_if.source dout
);
  import s8dp_pkg::*;

  localparam int SW = PROD_W + $clog2(LANES);

  logic signed [PROD_W-1:0] prod [LANES];
  ctrl_t                    ctrl1;
  ctrl_t                    ctrl1_next;
  ctrl_t                    ctrl2;
  logic signed [SW-1:0]     isum;
  logic                     merge_ready;
  logic                     acc_ready;
  logic                     en1;

  // The lane stage loads when empty or when its item moves on.
  assign en1       = !ctrl1.valid || merge_ready;
  assign din.ready = en1;

  assign ctrl1_next.valid = din.valid;
  assign ctrl1_next.last  = din.last;

  // Lane stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1 <= '0;
    end else if (en1) begin
      ctrl1 <= ctrl1_next;
    end
  end

  // One multiply lane per element pair.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    s8dp_lane u_lane (
      .clk  (clk),
      .en   (en1),
      .a    (din.a[i*EL_W +: EL_W]),
      .b    (din.b[i*EL_W +: EL_W]),
      .prod (prod[i])
    );
  end

  s8dp_merge #(.LANES(LANES)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .prod      (prod),
    .ctrl_in   (ctrl1),
    .acc_ready (acc_ready),
    .ready     (merge_ready),
    .ctrl_out  (ctrl2),
    .isum      (isum)
  );

  s8dp_accum #(.LANES(LANES)) u_accum (
    .clk       (clk),
    .rst       (rst),
    .ctrl_in   (ctrl2),
    .isum      (isum),
    .acc_ready (acc_ready),
    .dout      (dout)
  );

endmodule
